// ===== src/levels_remap_dither_assert.svh =====
// ----------------------------------------------------------------------------
// Levels remap with dither: assertion macros
// Short forms for the concurrent checks used in the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef LEVELS_REMAP_DITHER_ASSERT_SVH
`define LEVELS_REMAP_DITHER_ASSERT_SVH

// Check that cons holds in the same cycle whenever ante holds
`define LRD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante holds
`define LRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/lrd_pkg.sv =====
// ----------------------------------------------------------------------------
// Levels remap with dither: package
// Widths, register indexes and constants shared by the channel interfaces
// and the datapath.
// ----------------------------------------------------------------------------
package lrd_pkg;

   // Pixel channel width and lane count
   localparam int CH_W   = 8;
   localparam int CH_NUM = 3;

   // Configuration registers
   localparam int BLACK_W     = 17;
   localparam int GAIN_W      = 28;
   localparam int CSR_DATA_W  = 28;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_BLACK_LEVEL = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN        = 1'd1;

   localparam logic [BLACK_W-1:0] BLACK_RESET = 17'd0;
   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 28'd65536;

   // Curve points are 16-bit, clamped to full scale
   localparam int             T_W        = 16;
   localparam logic [T_W-1:0] FULL_SCALE = 16'd65280;

   // Datapath widths
   localparam int PROD_W = 36;   // channel times gain
   localparam int X_W    = 45;   // black times gain
   localparam int Y_W    = 53;   // black times gain times 255
   localparam int C_W    = 38;   // curve offset
   localparam int DIFF_W = 39;   // product minus offset
   localparam int D_W    = 17;   // difference of neighbouring points
   localparam int M_W    = 26;   // difference times dither
   localparam int ACC_W  = 20;   // dithered 16-bit value before cut

   // Cycles for the derived offset to follow a register write
   localparam int               SETTLE_W      = 2;
   localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

endpackage

// ===== src/lrd_req_if.sv =====
// ----------------------------------------------------------------------------
// Levels remap with dither: pixel request channel
// Valid/ready channel carrying one RGBA pixel and its dither value.
// ----------------------------------------------------------------------------
interface lrd_req_if
   import lrd_pkg::*;
();
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] red_in;
   logic [CH_W-1:0] green_in;
   logic [CH_W-1:0] blue_in;
   logic [CH_W-1:0] alpha_in;
   logic [CH_W-1:0] dither;

   modport source (output valid, red_in, green_in, blue_in, alpha_in, dither,
                   input ready);
   modport sink   (input valid, red_in, green_in, blue_in, alpha_in, dither,
                   output ready);
endinterface

// ===== src/lrd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Levels remap with dither: pixel response channel
// Valid/ready channel carrying one remapped RGBA pixel.
// ----------------------------------------------------------------------------
interface lrd_rsp_if
   import lrd_pkg::*;
();
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] red_out;
   logic [CH_W-1:0] green_out;
   logic [CH_W-1:0] blue_out;
   logic [CH_W-1:0] alpha_out;

   modport source (output valid, red_out, green_out, blue_out, alpha_out,
                   input ready);
   modport sink   (input valid, red_out, green_out, blue_out, alpha_out,
                   output ready);
endinterface

// ===== src/levels_remap_dither.sv =====
// ----------------------------------------------------------------------------
// Levels remap with dither: top level
// Stretches each colour channel between black and white levels and dithers
// the result back to 8 bits; alpha passes through.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while it is not stalled, through a
// four-stage pipeline (channel times gain, clamped curve points,
// difference times dither, rounding and clamp to the output register); a
// stall on the response side backs up through the stages without losing a
// beat. Every csr write, and reset, holds req ready low while the
// black-level offset is recomputed by its own three-stage multiply chain;
// after that the block runs at one pixel per clock unless the response stalls.

`include "levels_remap_dither_assert.svh"

module levels_remap_dither
   import lrd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   lrd_req_if.sink                req_bus,
   lrd_rsp_if.source              rsp_bus,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   // Configuration registers and settle counter
   logic        [BLACK_W-1:0]  black_ff;
   logic signed [GAIN_W-1:0]   gain_ff;
   logic        [SETTLE_W-1:0] settle_ff, settle_in;

   always_comb begin
      if (csr_wr_en) begin
         settle_in = SETTLE_CYCLES;
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         black_ff  <= BLACK_RESET;
         gain_ff   <= GAIN_RESET;
         settle_ff <= SETTLE_CYCLES;
      end else begin
         settle_ff <= settle_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_BLACK_LEVEL: black_ff <= csr_wr_data[BLACK_W-1:0];
               CSR_GAIN:        gain_ff  <= csr_wr_data[GAIN_W-1:0];
               default:         ;
            endcase
         end
      end
   end

   // Derive offset c = ceil(65280 * black * gain / 2^24) over three stages
   logic signed [X_W-1:0] x_ff, x_in;
   logic signed [Y_W-1:0] y_ff, y_in;
   logic signed [C_W-1:0] c_ff, c_in;
   logic signed [Y_W:0]   y_round;

   always_comb begin
      x_in    = X_W'($signed({1'b0, black_ff}) * gain_ff);
      y_in    = (Y_W'(x_ff) <<< 8) - Y_W'(x_ff);
      y_round = (Y_W+1)'(y_ff) + (Y_W+1)'(17'sd65535);
      c_in    = C_W'(y_round >>> 16);
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      c_ff <= c_in;
   end

   // Stage handshake: a stage loads when empty or when its successor moves
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;
   logic req_acc;

   assign s4_rdy        = !s4_v_ff || rsp_bus.ready;
   assign s3_rdy        = !s3_v_ff || s4_rdy;
   assign s2_rdy        = !s2_v_ff || s3_rdy;
   assign s1_rdy        = !s1_v_ff || s2_rdy;
   assign req_bus.ready = s1_rdy && (settle_ff == '0);
   assign req_acc       = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         if (s1_rdy) s1_v_ff <= req_acc;
         if (s2_rdy) s2_v_ff <= s1_v_ff;
         if (s3_rdy) s3_v_ff <= s2_v_ff;
         if (s4_rdy) s4_v_ff <= s3_v_ff;
      end
   end

   // Pass dither and alpha alongside the lanes
   logic [CH_W-1:0] dither1_ff, dither2_ff;
   logic [CH_W-1:0] alpha1_ff, alpha2_ff, alpha3_ff, alpha4_ff;

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         dither1_ff <= req_bus.dither;
         alpha1_ff  <= req_bus.alpha_in;
      end
      if (s2_rdy) begin
         dither2_ff <= dither1_ff;
         alpha2_ff  <= alpha1_ff;
      end
      if (s3_rdy) alpha3_ff <= alpha2_ff;
      if (s4_rdy) alpha4_ff <= alpha3_ff;
   end

   // Colour lanes
   logic        [CH_W-1:0]   chan     [CH_NUM];
   logic signed [PROD_W-1:0] p_lo_ff  [CH_NUM];
   logic signed [PROD_W-1:0] p_hi_ff  [CH_NUM];
   logic        [T_W-1:0]    t_lo_ff  [CH_NUM];
   logic        [T_W-1:0]    t_hi_ff  [CH_NUM];
   logic        [T_W-1:0]    lo_ff    [CH_NUM];
   logic signed [D_W-1:0]    d_ff     [CH_NUM];
   logic signed [M_W-1:0]    m_ff     [CH_NUM];
   logic        [CH_W-1:0]   out_ff   [CH_NUM];

   assign chan[0] = req_bus.red_in;
   assign chan[1] = req_bus.green_in;
   assign chan[2] = req_bus.blue_in;

   for (genvar k = 0; k < CH_NUM; k++) begin : g_lane
      logic        [CH_W-1:0]   next_chan;
      logic signed [PROD_W-1:0] p_lo_in, p_hi_in;
      logic signed [DIFF_W-1:0] diff_lo, diff_hi, sh_lo, sh_hi;
      logic        [T_W-1:0]    t_lo_in, t_hi_in;
      logic signed [D_W-1:0]    d_in;
      logic signed [M_W-1:0]    m_in;
      logic signed [ACC_W-1:0]  acc, v;
      logic        [CH_W-1:0]   out_in;

      // Stage 1: multiply the channel and its upper neighbour by the gain
      always_comb begin
         next_chan = (chan[k] == '1) ? chan[k] : chan[k] + 1'b1;
         p_lo_in   = PROD_W'($signed({1'b0, chan[k]}) * gain_ff);
         p_hi_in   = PROD_W'($signed({1'b0, next_chan}) * gain_ff);
      end

      // Stage 2: subtract the black offset, scale down and clamp
      always_comb begin
         diff_lo = DIFF_W'(p_lo_ff[k]) - DIFF_W'(c_ff);
         diff_hi = DIFF_W'(p_hi_ff[k]) - DIFF_W'(c_ff);
         sh_lo   = diff_lo >>> 8;
         sh_hi   = diff_hi >>> 8;
         priority if (sh_lo[DIFF_W-1]) begin
            t_lo_in = '0;
         end else if (sh_lo > DIFF_W'(FULL_SCALE)) begin
            t_lo_in = FULL_SCALE;
         end else begin
            t_lo_in = sh_lo[T_W-1:0];
         end
         priority if (sh_hi[DIFF_W-1]) begin
            t_hi_in = '0;
         end else if (sh_hi > DIFF_W'(FULL_SCALE)) begin
            t_hi_in = FULL_SCALE;
         end else begin
            t_hi_in = sh_hi[T_W-1:0];
         end
      end

      // Stage 3: point difference and its dithered share
      always_comb begin
         d_in = $signed({1'b0, t_hi_ff[k]}) - $signed({1'b0, t_lo_ff[k]});
         m_in = M_W'(d_in * $signed({1'b0, dither2_ff}));
      end

      // Stage 4: add the dither offset, drop to 8 bits and clamp
      always_comb begin
         acc = ACC_W'($signed({1'b0, lo_ff[k]})) + ACC_W'(m_ff[k] >>> 8)
             - ACC_W'(d_ff[k] >>> 1);
         v   = acc >>> 8;
         priority if (v[ACC_W-1]) begin
            out_in = '0;
         end else if (v > ACC_W'(8'd255)) begin
            out_in = '1;
         end else begin
            out_in = v[CH_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (s1_rdy) begin
            p_lo_ff[k] <= p_lo_in;
            p_hi_ff[k] <= p_hi_in;
         end
         if (s2_rdy) begin
            t_lo_ff[k] <= t_lo_in;
            t_hi_ff[k] <= t_hi_in;
         end
         if (s3_rdy) begin
            lo_ff[k] <= t_lo_ff[k];
            d_ff[k]  <= d_in;
            m_ff[k]  <= m_in;
         end
         if (s4_rdy) begin
            out_ff[k] <= out_in;
         end
      end
   end

   // Drive the response beat from the output register
   assign rsp_bus.valid     = s4_v_ff;
   assign rsp_bus.red_out   = out_ff[0];
   assign rsp_bus.green_out = out_ff[1];
   assign rsp_bus.blue_out  = out_ff[2];
   assign rsp_bus.alpha_out = alpha4_ff;

   // Checks
   `LRD_ASSERT_NEXT(a_csr_blocks_req, clock, reset, csr_wr_en, !req_bus.ready,
      "req ready high right after a csr write")
   `LRD_ASSERT_SAME(a_curve_in_range, clock, reset, s2_v_ff,
      (t_lo_ff[0] <= FULL_SCALE) && (t_hi_ff[0] <= FULL_SCALE),
      "curve point above full scale")
   `LRD_ASSERT_NEXT(a_stall_keeps_beats, clock, reset,
      s3_v_ff && s4_v_ff && !rsp_bus.ready, s3_v_ff && s4_v_ff,
      "beat lost under output stall")
   `LRD_ASSERT_NEXT(a_accept_fills_s1, clock, reset, req_acc, s1_v_ff,
      "accepted beat missing from first stage")

endmodule
